### rtl/assert_macros.svh
// Assertion macros shared by the cursor block RTL.
// Each expects clk_i in the module; PMTC_ASSERT also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PMTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PMTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/pmtc_pkg.sv
// Types and constants for the mouse packet to text cursor block.
// Used by the front, queue, back and top level modules.
`default_nettype none

package pmtc_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned BTN_W  = 3;
  localparam int unsigned STEP_W = 3;

  localparam int unsigned DEF_SCREEN_COLS = 80;
  localparam int unsigned DEF_SCREEN_ROWS = 25;
  localparam int unsigned DEF_START_COL   = 40;
  localparam int unsigned DEF_START_ROW   = 12;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

  typedef enum logic [2:0] {
    POS_BUTTONS = 3'b001,
    POS_DX      = 3'b010,
    POS_DY      = 3'b100
  } pos_e;

  typedef struct packed {
    logic [COL_W-1:0]  old_col;
    logic [ROW_W-1:0]  old_row;
    logic [COL_W-1:0]  new_col;
    logic [ROW_W-1:0]  new_row;
    logic [BTN_W-1:0]  buttons;
    logic [STEP_W-1:0] last_step;
  } job_t;

endpackage

`default_nettype wire

### rtl/pmtc_front.sv
// Front end: takes controller bytes, assembles mouse packets, moves the cursor.
// Pushes one cell-run job per complete packet into the queue; uses pmtc_pkg.
`default_nettype none
`include "assert_macros.svh"

module pmtc_front import pmtc_pkg::*; #(
  parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int unsigned START_COL   = DEF_START_COL,
  parameter int unsigned START_ROW   = DEF_START_ROW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic              aux_ready_i,
  input  logic              full_i,
  output logic              push_o,
  output job_t              job_o
);

  localparam logic signed [9:0] ColMax = 10'(SCREEN_COLS - 1);
  localparam logic signed [9:0] RowMax = 10'(SCREEN_ROWS - 1);

  pos_e              pos_q, pos_d;
  logic [DATA_W-1:0] byte0_q, byte0_d;
  logic [DATA_W-1:0] byte1_q, byte1_d;
  logic [COL_W-1:0]  cursor_col_q, cursor_col_d;
  logic [ROW_W-1:0]  cursor_row_q, cursor_row_d;
  logic [BTN_W-1:0]  prior_btn_q, prior_btn_d;

  logic              take;
  logic              third;
  logic signed [9:0] col_sum, row_sum;
  logic [COL_W-1:0]  new_col;
  logic [ROW_W-1:0]  new_row;
  logic [BTN_W-1:0]  btn, changed;

  assign in_stall_o = full_i;
  assign take       = in_valid_i && !full_i && aux_ready_i;
  assign third      = (pos_q != POS_BUTTONS) && (pos_q != POS_DX);

  assign col_sum = signed'({3'b000, cursor_col_q}) + signed'({{2{byte1_q[7]}}, byte1_q});
  assign row_sum = signed'({5'b00000, cursor_row_q})
                 - signed'({{2{data_byte_i[7]}}, data_byte_i});

  always_comb begin
    priority if (col_sum > ColMax) begin
      new_col = ColMax[COL_W-1:0];
    end else if (col_sum < 0) begin
      new_col = '0;
    end else begin
      new_col = col_sum[COL_W-1:0];
    end
    priority if (row_sum > RowMax) begin
      new_row = RowMax[ROW_W-1:0];
    end else if (row_sum < 0) begin
      new_row = '0;
    end else begin
      new_row = row_sum[ROW_W-1:0];
    end
  end

  assign btn     = byte0_q[BTN_W-1:0];
  assign changed = btn ^ prior_btn_q;

  assign push_o            = take && third;
  assign job_o.old_col     = cursor_col_q;
  assign job_o.old_row     = cursor_row_q;
  assign job_o.new_col     = new_col;
  assign job_o.new_row     = new_row;
  assign job_o.buttons     = btn;
  assign job_o.last_step   = STEP_W'(1) + {2'b00, changed[0]} + {2'b00, changed[1]}
                           + {2'b00, changed[2]};

  always_comb begin
    pos_d        = pos_q;
    byte0_d      = byte0_q;
    byte1_d      = byte1_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    prior_btn_d  = prior_btn_q;
    if (take) begin
      unique case (pos_q)
        POS_BUTTONS: begin
          byte0_d = data_byte_i;
          pos_d   = POS_DX;
        end
        POS_DX: begin
          byte1_d = data_byte_i;
          pos_d   = POS_DY;
        end
        default: begin
          pos_d        = POS_BUTTONS;
          cursor_col_d = new_col;
          cursor_row_d = new_row;
          prior_btn_d  = btn;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_BUTTONS;
      byte0_q      <= '0;
      byte1_q      <= '0;
      cursor_col_q <= COL_W'(START_COL);
      cursor_row_q <= ROW_W'(START_ROW);
      prior_btn_q  <= '0;
    end else begin
      pos_q        <= pos_d;
      byte0_q      <= byte0_d;
      byte1_q      <= byte1_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      prior_btn_q  <= prior_btn_d;
    end
  end

  `PMTC_ASSERT(a_cursor_on_screen, push_o |=> ({1'b0, cursor_col_q} < 8'(SCREEN_COLS)) && ({1'b0, cursor_row_q} < 6'(SCREEN_ROWS)), "cursor left the screen after a packet")

endmodule

`default_nettype wire

### rtl/pmtc_queue.sv
// Short job queue between the packet front end and the cell emitter.
// Holds QUEUE_DEPTH jobs of type job_t from pmtc_pkg.
`default_nettype none
`include "assert_macros.svh"

module pmtc_queue import pmtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] count_q;

  assign full_o  = count_q == QUEUE_CW'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QUEUE_CW'(1);
        2'b01:   count_q <= count_q - QUEUE_CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `PMTC_ASSERT(a_no_push_full, push_i |-> !full_o, "job pushed into a full queue")
  `PMTC_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "job popped from an empty queue")
  `PMTC_ASSERT(a_count_bound, count_q <= QUEUE_CW'(QUEUE_DEPTH), "queue count overrun")

endmodule

`default_nettype wire

### rtl/pmtc_back.sv
// Back end: walks each queued job and emits its text cells one per cycle,
// when not stalled. Owns the output register; uses job_t from pmtc_pkg.
`default_nettype none
`include "assert_macros.svh"

module pmtc_back import pmtc_pkg::*; #(
  parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  job_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [COL_W-1:0] cell_col_o,
  output logic [ROW_W-1:0] cell_row_o,
  output logic [IDX_W-1:0] cell_index_o,
  output logic [BTN_W-1:0] button_bits_o,
  output logic             last_of_run_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BTN_W-1:0]  btn_q;
  logic              last_q;

  logic              advance, load, last;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [11:0]       idx_full;

  assign advance = !out_valid_q || !out_stall_i;
  assign load    = advance && !empty_i;
  assign last    = step_q == head_i.last_step;
  assign pop_o   = load && last;

  assign col      = (step_q == '0) ? head_i.old_col : head_i.new_col;
  assign row      = (step_q == '0) ? head_i.old_row : head_i.new_row;
  assign idx_full = 12'(SCREEN_COLS) * {7'b0000000, row} + {5'b00000, col};

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = !empty_i;
    end
    if (load) begin
      step_d = last ? '0 : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q  <= col;
      row_q  <= row;
      idx_q  <= idx_full[IDX_W-1:0];
      btn_q  <= head_i.buttons;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_col_o    = col_q;
  assign cell_row_o    = row_q;
  assign cell_index_o  = idx_q;
  assign button_bits_o = btn_q;
  assign last_of_run_o = last_q;

  `PMTC_ASSERT(a_step_bound, !empty_i |-> step_q <= head_i.last_step, "cell step ran past the job")

endmodule

`default_nettype wire

### rtl/ps2_mouse_text_cursor_core.sv
// Mouse packet to text cursor core. A byte is taken every cycle unless the job queue is full.
// A third packet byte writes a job into the queue, and the back end loads its cells into the
// output register; its 2 to 5 cells leave at one per cycle unless out_stall_i is high.
// Reset (async, active low) clears the packet position, queue and output valid, puts the
// cursor at the start cell and clears the button history; no clearing pass is needed.
`default_nettype none

module ps2_mouse_text_cursor_core import pmtc_pkg::*; #(
  parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int unsigned START_COL   = DEF_START_COL,
  parameter int unsigned START_ROW   = DEF_START_ROW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic              aux_ready_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  cell_col_o,
  output logic [ROW_W-1:0]  cell_row_o,
  output logic [IDX_W-1:0]  cell_index_o,
  output logic [BTN_W-1:0]  button_bits_o,
  output logic              last_of_run_o
);

  logic full, push, empty, pop;
  job_t job, head;

  pmtc_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .START_COL   (START_COL),
    .START_ROW   (START_ROW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .aux_ready_i (aux_ready_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  pmtc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  pmtc_back #(
    .SCREEN_COLS (SCREEN_COLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_col_o    (cell_col_o),
    .cell_row_o    (cell_row_o),
    .cell_index_o  (cell_index_o),
    .button_bits_o (button_bits_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

### bench/ps2_mouse_text_cursor_core_tb.sv
// Self-checking bench for ps2_mouse_text_cursor_core: drives controller bytes and
// predicts the cursor cells that each complete mouse packet emits.
// Depends on pmtc_pkg and the core RTL only.
`default_nettype none

module ps2_mouse_text_cursor_core_tb import pmtc_pkg::*;;

  localparam int COLS       = DEF_SCREEN_COLS;
  localparam int ROWS       = DEF_SCREEN_ROWS;
  localparam int HOME_COL   = DEF_START_COL;
  localparam int HOME_ROW   = DEF_START_ROW;
  localparam int AUX_TARGET = 500;
  localparam int HOLD_LEN   = 150;
  localparam int SETTLE     = 10;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              aux;
  } ctrl_byte_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] index;
    logic [BTN_W-1:0] buttons;
    logic             last;
  } cell_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] in_data = '0;
  logic              in_aux = 1'b0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [COL_W-1:0]  cell_col_o;
  logic [ROW_W-1:0]  cell_row_o;
  logic [IDX_W-1:0]  cell_index_o;
  logic [BTN_W-1:0]  button_bits_o;
  logic              last_of_run_o;

  ps2_mouse_text_cursor_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (in_data),
    .aux_ready_i  (in_aux),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .cell_col_o   (cell_col_o),
    .cell_row_o   (cell_row_o),
    .cell_index_o (cell_index_o),
    .button_bits_o(button_bits_o),
    .last_of_run_o(last_of_run_o)
  );

  ctrl_byte_t       pending_bytes[$];
  cell_t            expected_cells[$];
  int               bytes_queued = 0;
  int               bytes_taken = 0;
  int               errors = 0;
  int               cells_seen = 0;

  pos_e             byte_pos = POS_BUTTONS;
  logic [DATA_W-1:0] btn_byte = '0;
  logic [DATA_W-1:0] dx_byte = '0;
  logic [COL_W-1:0] cur_col = COL_W'(HOME_COL);
  logic [ROW_W-1:0] cur_row = ROW_W'(HOME_ROW);
  logic [BTN_W-1:0] prev_btn = '0;

  function automatic cell_t make_cell(input logic [COL_W-1:0] col,
                                      input logic [ROW_W-1:0] row,
                                      input logic [BTN_W-1:0] btn);
    cell_t c;
    c.col     = col;
    c.row     = row;
    c.index   = IDX_W'(COLS * int'(row) + int'(col));
    c.buttons = btn;
    c.last    = 1'b0;
    return c;
  endfunction

  function automatic void track_mouse_byte(input logic [DATA_W-1:0] data, input logic aux);
    int               ncol;
    int               nrow;
    logic [BTN_W-1:0] btn;
    logic [BTN_W-1:0] changed;
    cell_t            run[$];
    if (!aux) return;
    if (byte_pos == POS_BUTTONS) begin
      btn_byte = data;
      byte_pos = POS_DX;
      return;
    end
    if (byte_pos == POS_DX) begin
      dx_byte  = data;
      byte_pos = POS_DY;
      return;
    end
    byte_pos = POS_BUTTONS;
    ncol = int'(cur_col) + int'($signed(dx_byte));
    nrow = int'(cur_row) - int'($signed(data));
    if (ncol > COLS - 1) ncol = COLS - 1;
    if (ncol < 0) ncol = 0;
    if (nrow > ROWS - 1) nrow = ROWS - 1;
    if (nrow < 0) nrow = 0;
    btn      = btn_byte[BTN_W-1:0];
    changed  = btn ^ prev_btn;
    prev_btn = btn;
    run.push_back(make_cell(cur_col, cur_row, btn));
    cur_col = COL_W'(ncol);
    cur_row = ROW_W'(nrow);
    run.push_back(make_cell(cur_col, cur_row, btn));
    for (int i = 0; i < BTN_W; i++)
      if (changed[i]) run.push_back(make_cell(cur_col, cur_row, btn));
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_cells.push_back(run[i]);
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [DATA_W-1:0] pick_motion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return DATA_W'($urandom_range(0, 10) - 5);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h81;
        default: return 8'h7E;
      endcase
    end
    return DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(input logic [DATA_W-1:0] data, input logic aux);
    ctrl_byte_t b;
    b.data = data;
    b.aux  = aux;
    pending_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void add_packet(input logic [DATA_W-1:0] b0,
                                     input logic [DATA_W-1:0] b1,
                                     input logic [DATA_W-1:0] b2);
    add_byte(b0, 1'b1);
    add_byte(b1, 1'b1);
    add_byte(b2, 1'b1);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver
  logic       in_steady = 1'b0;
  int         in_gap = 0;
  logic       in_busy;
  ctrl_byte_t in_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      in_busy = in_valid;
      if (in_valid && !in_stall_o) begin
        track_mouse_byte(in_data, in_aux);
        bytes_taken++;
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_bytes.size() > 0) begin
          in_next = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data  <= in_next.data;
          in_aux   <= in_next.aux;
          if ($urandom_range(0, 39) == 0) in_steady <= !in_steady;
          in_gap <= in_steady ? 0 : idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  logic  out_steady = 1'b0;
  logic  held = 1'b0;
  int    hold_left = 0;
  int    stall_left = 0;
  int    stall_pick;
  cell_t got_cell;
  cell_t want_cell;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        got_cell = {cell_col_o, cell_row_o, cell_index_o, button_bits_o, last_of_run_o};
        cells_seen++;
        if (expected_cells.size() == 0) begin
          errors++;
          $display("%0t: unexpected cell col=%0d row=%0d idx=%0d btn=%0d last=%0d", $time,
                   got_cell.col, got_cell.row, got_cell.index, got_cell.buttons,
                   got_cell.last);
        end else begin
          want_cell = expected_cells.pop_front();
          if (got_cell !== want_cell) begin
            errors++;
            $display("%0t: cell mismatch expected col=%0d row=%0d idx=%0d btn=%0d last=%0d",
                     $time, want_cell.col, want_cell.row, want_cell.index,
                     want_cell.buttons, want_cell.last);
            $display("%0t:               actual col=%0d row=%0d idx=%0d btn=%0d last=%0d",
                     $time, got_cell.col, got_cell.row, got_cell.index, got_cell.buttons,
                     got_cell.last);
          end
        end
      end
      if ($urandom_range(0, 79) == 0) out_steady <= !out_steady;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held && cells_seen >= 40) begin
        held      <= 1'b1;
        out_stall <= 1'b1;
        hold_left <= HOLD_LEN - 1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_pick = out_steady ? 0 : idle_length();
        out_stall  <= (stall_pick > 0);
        stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int               aux_count;
  int               r;
  logic [DATA_W-1:0] keep_btn;

  initial begin
    // ignored bytes, then extremes of movement and every button change
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_packet(8'h07, 8'h7F, 8'h80);
    add_packet(8'hF8, 8'h80, 8'h7F);
    add_packet(8'h01, 8'h00, 8'h00);
    add_byte(8'h01, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'h05, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_packet(8'h02, 8'hFF, 8'h01);
    add_packet(8'h04, 8'h01, 8'h00);

    aux_count = 0;
    keep_btn  = '0;
    while (aux_count < AUX_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
      end else if (r < 12) begin
        add_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
        aux_count++;
      end else begin
        if ($urandom_range(0, 2) != 0) keep_btn = DATA_W'($urandom_range(0, 255));
        add_byte(keep_btn, 1'b1);
        if ($urandom_range(0, 15) == 0) add_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
        add_byte(pick_motion(), 1'b1);
        if ($urandom_range(0, 15) == 0) add_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
        add_byte(pick_motion(), 1'b1);
        aux_count += 3;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < bytes_queued) @(posedge clk_i);
    while (expected_cells.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
